[sv/rgbhsv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// types, constants and the divider step shared by the rgb to hsv pipeline
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int QUOT_BITS    = 16;
	localparam int DVD_BITS     = QUOT_BITS + CHANNEL_BITS;
	localparam int HUE_BITS     = 15;
	localparam int SAT_BITS     = 16;
	localparam int SAT_SHIFT    = 15;
	localparam int DIV_STEPS    = 4;

	localparam logic [DVD_BITS-1:0] HUE_SIXTY = DVD_BITS'(3840);
	localparam logic [HUE_BITS-1:0] HUE_120   = HUE_BITS'(7680);
	localparam logic [HUE_BITS-1:0] HUE_240   = HUE_BITS'(15360);
	localparam logic [HUE_BITS-1:0] HUE_360   = HUE_BITS'(23040);

	typedef logic [CHANNEL_BITS-1:0] chan_t;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// one long division: partial remainder, dividend bits still to go
	// with quotient bits shifted in behind them, and the divisor
	typedef struct packed {
		chan_t                 rem;
		logic [QUOT_BITS-1:0]  work;
		chan_t                 den;
	} lane_t;

	typedef struct packed {
		chan_t   value;
		logic    gray;
		sector_t sector;
		logic    neg;
	} side_t;

	typedef struct packed {
		lane_t hue;
		lane_t sat;
		side_t side;
	} stg_t;

	function automatic lane_t lane_load(logic [DVD_BITS-1:0] dvd, chan_t den);
		lane_t l;
		l.rem  = dvd[DVD_BITS-1:QUOT_BITS];
		l.work = dvd[QUOT_BITS-1:0];
		l.den  = den;
		return l;
	endfunction

	// restoring division, four quotient bits per call
	function automatic lane_t div_step(lane_t l);
		lane_t                o;
		logic [CHANNEL_BITS:0] t;
		o = l;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t = {o.rem, o.work[QUOT_BITS-1]};
			if (t >= {1'b0, o.den}) begin
				o.rem  = CHANNEL_BITS'(t - {1'b0, o.den});
				o.work = {o.work[QUOT_BITS-2:0], 1'b1};
			end else begin
				o.rem  = t[CHANNEL_BITS-1:0];
				o.work = {o.work[QUOT_BITS-2:0], 1'b0};
			end
		end
		return o;
	endfunction

endpackage

[sv/rgbhsv_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_front
// max, min and sector pick, then spread and the two dividends
// ----------------------------------------------------------------------------
module rgbhsv_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  rgbhsv_pkg::chan_t    red,
	input  rgbhsv_pkg::chan_t    green,
	input  rgbhsv_pkg::chan_t    blue,
	input  logic                 en_next,
	output logic                 valid_s2,
	output rgbhsv_pkg::stg_t     stg_s2
);
	import rgbhsv_pkg::*;

	logic    en1, en2;
	logic    valid_s1;
	chan_t   max_s1, min_s1, pos_s1, neg_s1;
	sector_t sector_s1;

	chan_t   mx, mn, pos, neg;
	sector_t sector;

	chan_t              spread, diff;
	logic               is_neg;
	logic [DVD_BITS-1:0] hue_dvd, sat_dvd;
	stg_t               stg_d;

	assign en2       = !valid_s2 || en_next;
	assign en1       = !valid_s1 || en2;
	assign pix_stall = !en1;

	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		priority if (red >= green && red >= blue) begin
			sector = SEC_RED;
			pos    = green;
			neg    = blue;
		end else if (green >= blue) begin
			sector = SEC_GREEN;
			pos    = blue;
			neg    = red;
		end else begin
			sector = SEC_BLUE;
			pos    = red;
			neg    = green;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			max_s1    <= mx;
			min_s1    <= mn;
			pos_s1    <= pos;
			neg_s1    <= neg;
			sector_s1 <= sector;
		end
	end

	always_comb begin
		spread  = max_s1 - min_s1;
		is_neg  = pos_s1 < neg_s1;
		diff    = is_neg ? (neg_s1 - pos_s1) : (pos_s1 - neg_s1);
		hue_dvd = HUE_SIXTY * DVD_BITS'(diff);
		sat_dvd = DVD_BITS'(spread) << SAT_SHIFT;
		stg_d.hue         = lane_load(hue_dvd, spread);
		stg_d.sat         = lane_load(sat_dvd, max_s1);
		stg_d.side.value  = max_s1;
		stg_d.side.gray   = (spread == '0);
		stg_d.side.sector = sector_s1;
		stg_d.side.neg    = is_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			stg_s2 <= stg_d;
		end
	end

endmodule

[sv/rgbhsv_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_div
// four-stage pipelined divider, hue and saturation lanes side by side
// ----------------------------------------------------------------------------
module rgbhsv_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s2,
	input  rgbhsv_pkg::stg_t     stg_s2,
	output logic                 en_in,
	input  logic                 en_next,
	output logic                 valid_s6,
	output rgbhsv_pkg::stg_t     stg_s6
);
	import rgbhsv_pkg::*;

	logic en3, en4, en5, en6;
	logic valid_s3, valid_s4, valid_s5;
	stg_t stg_s3, stg_s4, stg_s5;

	assign en6   = !valid_s6 || en_next;
	assign en5   = !valid_s5 || en6;
	assign en4   = !valid_s4 || en5;
	assign en3   = !valid_s3 || en4;
	assign en_in = en3;

	function automatic stg_t stg_step(stg_t s);
		stg_t o;
		o     = s;
		o.hue = div_step(s.hue);
		o.sat = div_step(s.sat);
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
			if (en6) valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) stg_s3 <= stg_step(stg_s2);
		if (en4) stg_s4 <= stg_step(stg_s3);
		if (en5) stg_s5 <= stg_step(stg_s4);
		if (en6) stg_s6 <= stg_step(stg_s5);
	end

endmodule

[sv/rgb_to_hsv_pixel.sv]
`timescale 1ns / 1ps
// throughput: one pixel per cycle while hsv_stall is low, set by the seven-stage pipeline
// (max/min, dividends, four divider stages of four quotient bits, hue assembly)
// a stalled result holds while empty stages still fill behind it
// reset: arst_n clears all valid bits, the pipeline comes up empty
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// 8-bit rgb pixel to hue (1/64 degree), saturation (1.0 = 32768) and value
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  rgbhsv_pkg::chan_t             red,
	input  rgbhsv_pkg::chan_t             green,
	input  rgbhsv_pkg::chan_t             blue,
	output logic                          hsv_valid,
	input  logic                          hsv_stall,
	output logic [rgbhsv_pkg::HUE_BITS-1:0] hue,
	output logic [rgbhsv_pkg::SAT_BITS-1:0] saturation,
	output rgbhsv_pkg::chan_t             value,
	output logic                          achromatic
);
	import rgbhsv_pkg::*;

	logic en7, en_div, valid_s2, valid_s6, valid_s7;
	stg_t stg_s2, stg_s6;

	logic [HUE_BITS-1:0] q_hue, hue_d, hue_s7;
	logic [SAT_BITS-1:0] sat_d, sat_s7;
	chan_t               value_s7;
	logic                gray_s7;

	assign en7 = !valid_s7 || !hsv_stall;

	rgbhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.en_next   (en_div),
		.valid_s2  (valid_s2),
		.stg_s2    (stg_s2)
	);

	rgbhsv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.stg_s2   (stg_s2),
		.en_in    (en_div),
		.en_next  (en7),
		.valid_s6 (valid_s6),
		.stg_s6   (stg_s6)
	);

	always_comb begin
		q_hue = stg_s6.hue.work[HUE_BITS-1:0];
		hue_d = '0;
		if (!stg_s6.side.gray) begin
			unique case (stg_s6.side.sector)
				SEC_RED: begin
					if (!stg_s6.side.neg) begin
						hue_d = q_hue;
					end else begin
						hue_d = HUE_360 - q_hue;
						if (hue_d >= HUE_360) hue_d = '0;
					end
				end
				SEC_GREEN: hue_d = stg_s6.side.neg ? (HUE_120 - q_hue) : (HUE_120 + q_hue);
				SEC_BLUE:  hue_d = stg_s6.side.neg ? (HUE_240 - q_hue) : (HUE_240 + q_hue);
				default:   hue_d = '0;
			endcase
		end
		sat_d = (stg_s6.side.value == '0) ? '0 : stg_s6.sat.work[SAT_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en7) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			hue_s7   <= hue_d;
			sat_s7   <= sat_d;
			value_s7 <= stg_s6.side.value;
			gray_s7  <= stg_s6.side.gray;
		end
	end

	assign hsv_valid  = valid_s7;
	assign hue        = hue_s7;
	assign saturation = sat_s7;
	assign value      = value_s7;
	assign achromatic = gray_s7;

	// a gray word always carries hue zero
	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && achromatic |-> hue == '0)
		else $error("gray word with nonzero hue");

	// hue stays on the circle and saturation at or below one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> hue < HUE_360 && saturation <= SAT_BITS'(32768))
		else $error("hue or saturation out of range");

	// with no result waiting the pipeline can always move
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!hsv_valid |-> !pix_stall)
		else $error("input stalled with empty output");

	// a stalled result word holds its hue and saturation
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv_stall |=> $stable(hue) && $stable(saturation) && hsv_valid)
		else $error("stalled result word changed");

endmodule
